[sv/inverse_transform_4x4_reconstruct_macros.svh]
// assertion macros for the 4x4 inverse transform block
// used by the top level only, no other dependencies
`ifndef INVERSE_TRANSFORM_4X4_RECONSTRUCT_MACROS_SVH
`define INVERSE_TRANSFORM_4X4_RECONSTRUCT_MACROS_SVH

// same-cycle implication
`define ITR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ITR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/itr_pkg.sv]
// shared types, widths and helpers of the 4x4 inverse transform block
// no dependencies
package itr_pkg;

   localparam int COEF_W = 16;
   localparam int T_W    = COEF_W + 6;
   localparam int H_W    = T_W + 6;
   localparam int V_W    = H_W - 10;
   localparam int S_W    = V_W + 1;
   localparam int DCP_W  = COEF_W + 9;
   localparam int DC_W   = DCP_W - 10;
   localparam int LANES  = 4;

   typedef logic signed [COEF_W-1:0] coef_type;
   typedef logic signed [T_W-1:0]    tval_type;
   typedef logic signed [DC_W-1:0]   dc_type;
   typedef logic signed [S_W-1:0]    sum_type;
   typedef logic [7:0]               pix_type;

   typedef enum logic {
      MODE_FULL = 1'b0,
      MODE_DC   = 1'b1
   } mode_type;

   function automatic pix_type clip_pix(input sum_type s);
      pix_type r;
      if (s < sum_type'(0)) begin
         r = 8'd0;
      end else if (s > sum_type'(255)) begin
         r = 8'd255;
      end else begin
         r = s[7:0];
      end
      return r;
   endfunction

endpackage

[sv/itr_ifs.sv]
// request and response channel interfaces
// depends on itr_pkg
interface itr_req_if;
   logic                     valid;
   logic                     ready;
   logic                     mode;
   logic signed [15:0]       coef_a;
   logic signed [15:0]       coef_b;
   logic signed [15:0]       coef_c;
   logic signed [15:0]       coef_d;
   itr_pkg::pix_type         pred_a;
   itr_pkg::pix_type         pred_b;
   itr_pkg::pix_type         pred_c;
   itr_pkg::pix_type         pred_d;

   modport source (output valid, mode, coef_a, coef_b, coef_c, coef_d,
                   pred_a, pred_b, pred_c, pred_d, input ready);
   modport sink (input valid, mode, coef_a, coef_b, coef_c, coef_d,
                 pred_a, pred_b, pred_c, pred_d, output ready);
endinterface

interface itr_rsp_if;
   logic             valid;
   logic             ready;
   itr_pkg::pix_type pix_a;
   itr_pkg::pix_type pix_b;
   itr_pkg::pix_type pix_c;
   itr_pkg::pix_type pix_d;
   logic [1:0]       row_index;
   logic             row_last;

   modport source (output valid, pix_a, pix_b, pix_c, pix_d, row_index, row_last,
                   input ready);
   modport sink (input valid, pix_a, pix_b, pix_c, pix_d, row_index, row_last,
                 output ready);
endinterface

[sv/inverse_transform_4x4_reconstruct.sv]
// 4x4 inverse transform with reconstruction, top level
// a block's rows reach rsp_chan via the block bank and the output register
// throughput: one request and one pixel row per cycle unless the bank is
//   busy or rsp_chan stalls; the single row merge stage drains the bank
// reset: synchronous active high; clears row count, mode and valid flags
// depends on itr_pkg, itr_ifs, itr_vlane, itr_hrow and the macros header
`include "inverse_transform_4x4_reconstruct_macros.svh"

module inverse_transform_4x4_reconstruct (
   input logic      clock,
   input logic      reset,
   itr_req_if.sink  req_chan,
   itr_rsp_if.source rsp_chan
);
   import itr_pkg::*;

   // load side
   logic [1:0] rows_ff;
   mode_type   mode_ff;
   coef_type   coef_ff [3][LANES];
   pix_type    pred_ff [3][LANES];

   // block bank
   tval_type   t_ff     [LANES][LANES];
   pix_type    bpred_ff [LANES][LANES];
   mode_type   bmode_ff;
   dc_type     dc_ff;
   logic       blk_valid_ff;
   logic [1:0] row_ff;

   // output register
   logic       rsp_valid_ff;
   pix_type    pix_ff [LANES];
   logic [1:0] ridx_ff;

   coef_type   cin [LANES];
   pix_type    pin [LANES];
   tval_type   t_in [LANES][LANES];
   logic signed [DCP_W-1:0] dcp;
   dc_type     dc_in;
   pix_type    hpix [LANES];

   logic req_fire, last_fire, out_ready, out_load, bank_free;

   always_comb begin
      cin[0] = req_chan.coef_a[COEF_W-1:0];
      cin[1] = req_chan.coef_b[COEF_W-1:0];
      cin[2] = req_chan.coef_c[COEF_W-1:0];
      cin[3] = req_chan.coef_d[COEF_W-1:0];
      pin[0] = req_chan.pred_a;
      pin[1] = req_chan.pred_b;
      pin[2] = req_chan.pred_c;
      pin[3] = req_chan.pred_d;
      dcp    = DCP_W'(coef_ff[0][0]) * DCP_W'(169) + DCP_W'(512);
      dc_in  = dcp[DCP_W-1:10];
   end

   assign out_ready = !rsp_valid_ff || rsp_chan.ready;
   assign out_load  = blk_valid_ff && out_ready;
   assign bank_free = !blk_valid_ff || (out_load && row_ff == 2'd3);
   assign req_chan.ready = (rows_ff != 2'd3) || bank_free;
   assign req_fire  = req_chan.valid && req_chan.ready;
   assign last_fire = req_fire && rows_ff == 2'd3;

   // column lanes
   for (genvar j = 0; j < LANES; j++) begin : g_lane
      itr_vlane u_vlane (
         .c0 (coef_ff[0][j]),
         .c1 (coef_ff[1][j]),
         .c2 (coef_ff[2][j]),
         .c3 (cin[j]),
         .t0 (t_in[0][j]),
         .t1 (t_in[1][j]),
         .t2 (t_in[2][j]),
         .t3 (t_in[3][j])
      );
   end

   itr_hrow u_hrow (
      .t_row (t_ff[row_ff]),
      .pred  (bpred_ff[row_ff]),
      .mode  (bmode_ff),
      .dc    (dc_ff),
      .pix   (hpix)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff      <= 2'd0;
         mode_ff      <= MODE_FULL;
         blk_valid_ff <= 1'b0;
         row_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            rows_ff <= rows_ff + 2'd1;
            if (rows_ff == 2'd0) begin
               mode_ff <= mode_type'(req_chan.mode);
            end
         end
         if (out_load) begin
            row_ff <= row_ff + 2'd1;
         end
         if (last_fire) begin
            blk_valid_ff <= 1'b1;
         end else if (out_load && row_ff == 2'd3) begin
            blk_valid_ff <= 1'b0;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (req_fire && rows_ff != 2'd3) begin
         coef_ff[rows_ff] <= cin;
         pred_ff[rows_ff] <= pin;
      end
      if (last_fire) begin
         t_ff        <= t_in;
         bpred_ff[0] <= pred_ff[0];
         bpred_ff[1] <= pred_ff[1];
         bpred_ff[2] <= pred_ff[2];
         bpred_ff[3] <= pin;
         bmode_ff    <= mode_ff;
         dc_ff       <= dc_in;
      end
      if (out_load) begin
         pix_ff  <= hpix;
         ridx_ff <= row_ff;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.pix_a     = pix_ff[0];
   assign rsp_chan.pix_b     = pix_ff[1];
   assign rsp_chan.pix_c     = pix_ff[2];
   assign rsp_chan.pix_d     = pix_ff[3];
   assign rsp_chan.row_index = ridx_ff;
   assign rsp_chan.row_last  = (ridx_ff == 2'd3);

   `ITR_ASSERT_NEXT(a_bank_loaded, clock, reset, last_fire, blk_valid_ff && row_ff == 2'd0, "bank not loaded after last request")
   `ITR_ASSERT_NOW(a_stall_cause, clock, reset, !req_chan.ready, rows_ff == 2'd3 && blk_valid_ff, "request stalled without a busy bank")
   `ITR_ASSERT_NOW(a_out_held, clock, reset, blk_valid_ff && row_ff != 2'd0, rsp_valid_ff, "output register empty mid block")

endmodule

[sv/itr_vlane.sv]
// column lane: vertical 13/7/17 butterfly over one coefficient column
// depends on itr_pkg
module itr_vlane (
   input  itr_pkg::coef_type c0,
   input  itr_pkg::coef_type c1,
   input  itr_pkg::coef_type c2,
   input  itr_pkg::coef_type c3,
   output itr_pkg::tval_type t0,
   output itr_pkg::tval_type t1,
   output itr_pkg::tval_type t2,
   output itr_pkg::tval_type t3
);
   import itr_pkg::*;

   tval_type e0, e1, e2, e3;
   tval_type z0, z1, z2, z3;

   always_comb begin
      e0 = tval_type'(c0);
      e1 = tval_type'(c1);
      e2 = tval_type'(c2);
      e3 = tval_type'(c3);
      z0 = (e0 + e2) * tval_type'(13);
      z1 = (e0 - e2) * tval_type'(13);
      z2 = e1 * tval_type'(7) - e3 * tval_type'(17);
      z3 = e1 * tval_type'(17) + e3 * tval_type'(7);
      t0 = z0 + z3;
      t1 = z1 + z2;
      t2 = z1 - z2;
      t3 = z0 - z3;
   end

endmodule

[sv/itr_hrow.sv]
// merge stage: horizontal butterfly of one row, rounding, dc path,
// prediction add and clip; depends on itr_pkg
module itr_hrow (
   input  itr_pkg::tval_type t_row [itr_pkg::LANES],
   input  itr_pkg::pix_type  pred  [itr_pkg::LANES],
   input  itr_pkg::mode_type mode,
   input  itr_pkg::dc_type   dc,
   output itr_pkg::pix_type  pix   [itr_pkg::LANES]
);
   import itr_pkg::*;

   typedef logic signed [H_W-1:0] hval_type;
   typedef logic signed [V_W-1:0] vval_type;

   hval_type e0, e1, e2, e3;
   hval_type z0, z1, z2, z3;
   hval_type h [LANES];
   vval_type v [LANES];

   always_comb begin
      e0 = hval_type'(t_row[0]);
      e1 = hval_type'(t_row[1]);
      e2 = hval_type'(t_row[2]);
      e3 = hval_type'(t_row[3]);
      z0 = (e0 + e2) * hval_type'(13) + hval_type'(512);
      z1 = (e0 - e2) * hval_type'(13) + hval_type'(512);
      z2 = e1 * hval_type'(7) - e3 * hval_type'(17);
      z3 = e1 * hval_type'(17) + e3 * hval_type'(7);
      h[0] = z0 + z3;
      h[1] = z1 + z2;
      h[2] = z1 - z2;
      h[3] = z0 - z3;
      for (int j = 0; j < LANES; j++) begin
         if (mode == MODE_DC) begin
            v[j] = vval_type'(dc);
         end else begin
            v[j] = h[j][H_W-1:10];
         end
         pix[j] = clip_pix(sum_type'(v[j]) + sum_type'({1'b0, pred[j]}));
      end
   end

endmodule
